/* sv/rufs_pkg.sv */
// Shared types and constants for the request URI field splitter.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package rufs_pkg;

	// Default limits, handed down through the top level's parameters.
	localparam int MAX_REQUEST_DEF    = 1024;
	localparam int MAX_SCHEME_LEN_DEF = 16;
	localparam int MAX_DOMAIN_LEN_DEF = 256;
	localparam int MAX_PORT_LEN_DEF   = 8;
	localparam int MAX_PATH_LEN_DEF   = 512;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Characters that steer the parser.
	localparam logic [7:0]  CH_COLON  = 8'h3A;
	localparam logic [7:0]  CH_SLASH  = 8'h2F;
	localparam logic [7:0]  CH_QMARK  = 8'h3F;
	localparam logic [7:0]  CH_CR     = 8'h0D;
	localparam logic [7:0]  CH_LF     = 8'h0A;
	localparam logic [15:0] TERM_CRLF = 16'h0D0A;

	// Field tags of kept characters.
	localparam logic [1:0] TAG_SCHEME = 2'd0;
	localparam logic [1:0] TAG_DOMAIN = 2'd1;
	localparam logic [1:0] TAG_PORT   = 2'd2;
	localparam logic [1:0] TAG_PATH   = 2'd3;

	// Error flag bits of the status word.
	localparam logic [4:0] ERR_TERM   = 5'b00001;
	localparam logic [4:0] ERR_SCHEME = 5'b00010;
	localparam logic [4:0] ERR_DOMAIN = 5'b00100;
	localparam logic [4:0] ERR_PORT   = 5'b01000;
	localparam logic [4:0] ERR_PATH   = 5'b10000;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_SCHEME = 3'd0,
		PH_SLASH1 = 3'd1,
		PH_SLASH2 = 3'd2,
		PH_DOMAIN = 3'd3,
		PH_PORT   = 3'd4,
		PH_PATH   = 3'd5,
		PH_STOP   = 3'd6
	} phase_t;

	// One classified input word as it travels from front to back.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       colon;
		logic       slash;
		logic       qmark;
		logic       crlf;
	} word_t;

endpackage
`default_nettype wire

/* sv/rufs_front.sv */
// Front stage: accepts input words and classifies each byte once.
// Depends on rufs_pkg for the word type and character constants.
`default_nettype none
module rufs_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     req_byte,
	input  wire logic           is_final,
	input  wire logic           in_valid,
	output logic                in_ready,
	output rufs_pkg::word_t     push_word,
	output logic                push_valid,
	input  wire logic           push_ready
);

	logic            valid_s1;
	rufs_pkg::word_t word_s1;

	// The stage takes a word whenever it is empty or is draining this cycle.
	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_word  = word_s1;

	// Control flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Classified payload; no reset needed.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1.data  <= req_byte;
			word_s1.last  <= is_final;
			word_s1.colon <= (req_byte == rufs_pkg::CH_COLON);
			word_s1.slash <= (req_byte == rufs_pkg::CH_SLASH);
			word_s1.qmark <= (req_byte == rufs_pkg::CH_QMARK);
			word_s1.crlf  <= (req_byte == rufs_pkg::CH_CR) || (req_byte == rufs_pkg::CH_LF);
		end
	end

endmodule
`default_nettype wire

/* sv/rufs_queue.sv */
// Short queue that decouples the classifying front from the parsing back.
// Depends on rufs_pkg for the word type and queue depth.
`default_nettype none
module rufs_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rufs_pkg::word_t push_word,
	input  wire logic            push_valid,
	output logic                 push_ready,
	output rufs_pkg::word_t      pop_word,
	output logic                 pop_valid,
	input  wire logic            pop_ready
);

	localparam int PW = (rufs_pkg::QUEUE_DEPTH > 1) ? $clog2(rufs_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(rufs_pkg::QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(rufs_pkg::QUEUE_DEPTH);
	localparam logic [PW-1:0] LASTP = PW'(rufs_pkg::QUEUE_DEPTH - 1);

	rufs_pkg::word_t slot_q [rufs_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_word   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LASTP) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LASTP) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL) else $error("queue count beyond depth");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("empty queue with split pointers");
`endif

endmodule
`default_nettype wire

/* sv/rufs_back.sv */
// Back stage: URI parser state, length checks and the registered result word.
// Depends on rufs_pkg for phases, tags, error bits and the word type.
`default_nettype none
module rufs_back #(
	parameter int MAX_REQUEST    = rufs_pkg::MAX_REQUEST_DEF,
	parameter int MAX_SCHEME_LEN = rufs_pkg::MAX_SCHEME_LEN_DEF,
	parameter int MAX_DOMAIN_LEN = rufs_pkg::MAX_DOMAIN_LEN_DEF,
	parameter int MAX_PORT_LEN   = rufs_pkg::MAX_PORT_LEN_DEF,
	parameter int MAX_PATH_LEN   = rufs_pkg::MAX_PATH_LEN_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rufs_pkg::word_t pop_word,
	input  wire logic            pop_valid,
	output logic                 pop_ready,
	output logic [7:0]           field_char,
	output logic [1:0]           field_tag,
	output logic                 is_status,
	output logic [4:0]           error_flags,
	output logic                 out_valid,
	input  wire logic            out_ready
);

	// Field length counter covers the largest field limit.
	localparam int MAXF1 = (MAX_SCHEME_LEN > MAX_DOMAIN_LEN) ? MAX_SCHEME_LEN : MAX_DOMAIN_LEN;
	localparam int MAXF2 = (MAX_PORT_LEN > MAX_PATH_LEN) ? MAX_PORT_LEN : MAX_PATH_LEN;
	localparam int MAXF  = (MAXF1 > MAXF2) ? MAXF1 : MAXF2;
	localparam int FLW   = $clog2(MAXF + 1);
	// Request counter saturates one past the limit.
	localparam int RLW   = $clog2(MAX_REQUEST + 2);

	localparam logic [FLW-1:0] LIM_SCHEME = FLW'(MAX_SCHEME_LEN);
	localparam logic [FLW-1:0] LIM_DOMAIN = FLW'(MAX_DOMAIN_LEN);
	localparam logic [FLW-1:0] LIM_PORT   = FLW'(MAX_PORT_LEN);
	localparam logic [FLW-1:0] LIM_PATH   = FLW'(MAX_PATH_LEN);
	localparam logic [FLW-1:0] FLEN_ONE   = FLW'(1);
	localparam logic [RLW-1:0] LIM_REQ    = RLW'(MAX_REQUEST);
	localparam logic [RLW-1:0] LIM_REQ1   = RLW'(MAX_REQUEST + 1);

	rufs_pkg::phase_t phase_q, phase_n;
	logic [FLW-1:0]   flen_q, flen_n;
	logic [RLW-1:0]   rlen_q, rlen_n;
	logic [4:0]       err_q, err_n;
	logic [15:0]      last_q, last_n;
	logic             ss_q, ss_n;
	logic             ds_q, ds_n;
	logic             ds_eff;
	logic             do_check;
	logic             keep;
	logic [1:0]       tag;
	logic             term_bad;
	logic             do_pop;

	// A word is parsed whenever the result register is free or being emptied.
	assign pop_ready = !out_valid || out_ready;
	assign do_pop    = pop_valid && pop_ready;

	// Next-state logic of the parser for the word at the queue head.
	always_comb begin
		phase_n  = phase_q;
		flen_n   = flen_q;
		err_n    = err_q;
		ss_n     = ss_q;
		ds_n     = ds_q;
		ds_eff   = ds_q;
		do_check = 1'b0;
		keep     = 1'b0;
		tag      = rufs_pkg::TAG_SCHEME;
		rlen_n   = (rlen_q <= LIM_REQ) ? rlen_q + 1'b1 : rlen_q;
		last_n   = {last_q[7:0], pop_word.data};

		if (err_q == '0 && phase_q != rufs_pkg::PH_STOP) begin
			if (pop_word.crlf) begin
				// Line end: close whatever field is open.
				phase_n = rufs_pkg::PH_STOP;
				case (phase_q)
					rufs_pkg::PH_SLASH1, rufs_pkg::PH_SLASH2: begin
						err_n = err_q | rufs_pkg::ERR_SCHEME;
					end
					rufs_pkg::PH_DOMAIN: begin
						if (flen_q >= LIM_DOMAIN) begin
							err_n = err_q | rufs_pkg::ERR_DOMAIN;
						end else begin
							ds_eff   = (flen_q != '0);
							ds_n     = ds_eff;
							do_check = 1'b1;
						end
					end
					rufs_pkg::PH_PORT: begin
						if (flen_q >= LIM_PORT) begin
							err_n = err_q | rufs_pkg::ERR_PORT;
						end else begin
							do_check = 1'b1;
						end
					end
					rufs_pkg::PH_PATH: begin
						if (flen_q >= LIM_PATH) begin
							err_n = err_q | rufs_pkg::ERR_PATH;
						end else begin
							do_check = 1'b1;
						end
					end
					default: begin
						do_check = 1'b1;
					end
				endcase
				if (do_check) begin
					if (!ss_q) begin
						err_n = err_n | rufs_pkg::ERR_SCHEME;
					end
					if (!ds_eff) begin
						err_n = err_n | rufs_pkg::ERR_DOMAIN;
					end
				end
			end else begin
				// Ordinary byte: walk the field grammar.
				case (phase_q)
					rufs_pkg::PH_SCHEME: begin
						if (flen_q >= LIM_SCHEME) begin
							err_n = err_q | rufs_pkg::ERR_SCHEME;
						end else if (pop_word.colon) begin
							ss_n    = (flen_q != '0);
							flen_n  = '0;
							phase_n = rufs_pkg::PH_SLASH1;
						end else begin
							flen_n = flen_q + 1'b1;
							keep   = 1'b1;
							tag    = rufs_pkg::TAG_SCHEME;
						end
					end
					rufs_pkg::PH_SLASH1: begin
						if (!pop_word.slash) begin
							err_n = err_q | rufs_pkg::ERR_SCHEME;
						end else begin
							phase_n = rufs_pkg::PH_SLASH2;
						end
					end
					rufs_pkg::PH_SLASH2: begin
						if (!pop_word.slash) begin
							err_n = err_q | rufs_pkg::ERR_SCHEME;
						end else begin
							phase_n = rufs_pkg::PH_DOMAIN;
						end
					end
					rufs_pkg::PH_DOMAIN: begin
						if (flen_q >= LIM_DOMAIN) begin
							err_n = err_q | rufs_pkg::ERR_DOMAIN;
						end else if (pop_word.colon) begin
							ds_n    = (flen_q != '0);
							flen_n  = '0;
							phase_n = rufs_pkg::PH_PORT;
						end else if (pop_word.slash) begin
							ds_n    = (flen_q != '0);
							flen_n  = FLEN_ONE;
							phase_n = rufs_pkg::PH_PATH;
							keep    = 1'b1;
							tag     = rufs_pkg::TAG_PATH;
						end else begin
							flen_n = flen_q + 1'b1;
							keep   = 1'b1;
							tag    = rufs_pkg::TAG_DOMAIN;
						end
					end
					rufs_pkg::PH_PORT: begin
						if (flen_q >= LIM_PORT) begin
							err_n = err_q | rufs_pkg::ERR_PORT;
						end else if (pop_word.slash) begin
							flen_n  = FLEN_ONE;
							phase_n = rufs_pkg::PH_PATH;
							keep    = 1'b1;
							tag     = rufs_pkg::TAG_PATH;
						end else begin
							flen_n = flen_q + 1'b1;
							keep   = 1'b1;
							tag    = rufs_pkg::TAG_PORT;
						end
					end
					rufs_pkg::PH_PATH: begin
						if (flen_q >= LIM_PATH) begin
							err_n = err_q | rufs_pkg::ERR_PATH;
						end else if (pop_word.qmark) begin
							if (!ds_q) begin
								err_n = err_q | rufs_pkg::ERR_DOMAIN;
							end
							phase_n = rufs_pkg::PH_STOP;
						end else begin
							flen_n = flen_q + 1'b1;
							keep   = 1'b1;
							tag    = rufs_pkg::TAG_PATH;
						end
					end
					default: begin
						keep = 1'b0;
					end
				endcase
			end
		end

		term_bad = (last_n != rufs_pkg::TERM_CRLF) || (rlen_n > LIM_REQ);
	end

	// Parser state; the final word of a request returns it to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rufs_pkg::PH_SCHEME;
			flen_q  <= '0;
			rlen_q  <= '0;
			err_q   <= '0;
			last_q  <= '0;
			ss_q    <= 1'b0;
			ds_q    <= 1'b0;
		end else if (do_pop) begin
			if (pop_word.last) begin
				phase_q <= rufs_pkg::PH_SCHEME;
				flen_q  <= '0;
				rlen_q  <= '0;
				err_q   <= '0;
				last_q  <= '0;
				ss_q    <= 1'b0;
				ds_q    <= 1'b0;
			end else begin
				phase_q <= phase_n;
				flen_q  <= flen_n;
				rlen_q  <= rlen_n;
				err_q   <= err_n;
				last_q  <= last_n;
				ss_q    <= ss_n;
				ds_q    <= ds_n;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (do_pop) begin
			out_valid <= pop_word.last || keep;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Result payload: a status word on the final byte, else a field character.
	always_ff @(posedge clk) begin
		if (do_pop) begin
			if (pop_word.last) begin
				field_char  <= '0;
				field_tag   <= rufs_pkg::TAG_SCHEME;
				is_status   <= 1'b1;
				error_flags <= term_bad ? rufs_pkg::ERR_TERM : err_n;
			end else begin
				field_char  <= pop_word.data;
				field_tag   <= tag;
				is_status   <= 1'b0;
				error_flags <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_status) |-> (field_char == '0 && field_tag == rufs_pkg::TAG_SCHEME))
		else $error("status word carries character data");
	a_field_noerr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_status) |-> (error_flags == '0))
		else $error("field word carries error flags");
	a_rlen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rlen_q <= LIM_REQ1) else $error("request counter beyond saturation");
	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && pop_word.last) |=> (phase_q == rufs_pkg::PH_SCHEME && rlen_q == '0
			&& err_q == '0 && out_valid && is_status))
		else $error("final word did not close the request");
`endif

endmodule
`default_nettype wire

/* sv/request_uri_field_splitter_core.sv */
// Top level of the request URI field splitter: front, queue and back.
// Depends on rufs_pkg, rufs_front, rufs_queue and rufs_back.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid / in_ready | req_byte, is_final
//   output  | out_valid/out_ready | field_char, field_tag, is_status, error_flags
//
// One byte per cycle sustained while the output is not stalled; a byte passes
// through the front register, then a queue slot, then the result register.
// Each byte causes at most one result word, so the parser pops one word per cycle
// whenever the result register is free or being taken.
// A stalled output fills the two-entry queue and then the front register before
// in_ready drops. Reset is asynchronous and active low and needs no clearing pass.
`default_nettype none
module request_uri_field_splitter_core #(
	parameter int MAX_REQUEST    = rufs_pkg::MAX_REQUEST_DEF,
	parameter int MAX_SCHEME_LEN = rufs_pkg::MAX_SCHEME_LEN_DEF,
	parameter int MAX_DOMAIN_LEN = rufs_pkg::MAX_DOMAIN_LEN_DEF,
	parameter int MAX_PORT_LEN   = rufs_pkg::MAX_PORT_LEN_DEF,
	parameter int MAX_PATH_LEN   = rufs_pkg::MAX_PATH_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] req_byte,
	input  wire logic       is_final,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic [7:0]      field_char,
	output logic [1:0]      field_tag,
	output logic            is_status,
	output logic [4:0]      error_flags,
	output logic            out_valid,
	input  wire logic       out_ready
);

	rufs_pkg::word_t push_word;
	rufs_pkg::word_t pop_word;
	logic            push_valid;
	logic            push_ready;
	logic            pop_valid;
	logic            pop_ready;

	// Byte classification.
	rufs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_byte   (req_byte),
		.is_final   (is_final),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.push_word  (push_word),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Decoupling queue.
	rufs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_word  (push_word),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_word   (pop_word),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// Parser and result register.
	rufs_back #(
		.MAX_REQUEST    (MAX_REQUEST),
		.MAX_SCHEME_LEN (MAX_SCHEME_LEN),
		.MAX_DOMAIN_LEN (MAX_DOMAIN_LEN),
		.MAX_PORT_LEN   (MAX_PORT_LEN),
		.MAX_PATH_LEN   (MAX_PATH_LEN)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_word    (pop_word),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.field_char  (field_char),
		.field_tag   (field_tag),
		.is_status   (is_status),
		.error_flags (error_flags),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for request_uri_field_splitter_core: directed and random requests.
// Depends on rufs_pkg and the core; expected words come from a predictor held here.
module tb_top;

	localparam int MAX_REQ  = rufs_pkg::MAX_REQUEST_DEF;
	localparam int MAX_SCH  = rufs_pkg::MAX_SCHEME_LEN_DEF;
	localparam int MAX_DOM  = rufs_pkg::MAX_DOMAIN_LEN_DEF;
	localparam int MAX_PORT = rufs_pkg::MAX_PORT_LEN_DEF;
	localparam int MAX_PTH  = rufs_pkg::MAX_PATH_LEN_DEF;

	localparam logic [4:0] NO_ERR = 5'd0;
	localparam int SMALL_PER_PHASE = 115;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NPROBE = 23;

	// Kinds of long request, one in each of the first two idling phases.
	localparam int LONG_DOMAIN = 0;
	localparam int LONG_PATH   = 1;

	typedef struct packed {
		logic [7:0] ch;
		logic [1:0] tag;
		logic       st;
		logic [4:0] flags;
	} result_t;

	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       pinned;
		logic [4:0] flags;
	} probe_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] req_byte = 8'd0;
	logic       is_final = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] field_char;
	logic [1:0] field_tag;
	logic       is_status;
	logic [4:0] error_flags;
	logic       out_valid;
	logic       out_ready = 1'b0;

	int send_idle_pct = 19;
	int recv_idle_pct = 55;
	int mismatches = 0;
	int cycles = 0;

	// Predictor state of the splitter.
	rufs_pkg::phase_t cur_phase;
	int unsigned      kept_len;
	int unsigned      req_len;
	logic [4:0]       err_acc;
	logic [15:0]      tail_pair;
	bit               have_scheme;
	bit               have_domain;

	result_t    pending_results[$];
	logic [7:0] line_buf[$];
	result_t    want;
	probe_t     probes [NPROBE];

	request_uri_field_splitter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_byte(req_byte),
		.is_final(is_final),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.field_char(field_char),
		.field_tag(field_tag),
		.is_status(is_status),
		.error_flags(error_flags),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	always #2 clk = ~clk;

	// Run-length guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				pending_results.size());
			$display("** request_uri_field_splitter_core: FAILED **");
			$finish;
		end
	end

	task automatic log_mismatch(input string what);
		if (mismatches < 40)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic void clear_split_state();
		cur_phase = rufs_pkg::PH_SCHEME;
		kept_len = 0;
		req_len = 0;
		err_acc = NO_ERR;
		tail_pair = 16'h0000;
		have_scheme = 0;
		have_domain = 0;
	endfunction

	// Advances the predictor by one byte; returns 1 when the byte yields a word.
	function automatic bit predict_split(input logic [7:0] b, input logic fin,
			output result_t r);
		bit keep;
		bit overfull;
		logic [1:0] tag;
		keep = 0;
		overfull = 0;
		tag = rufs_pkg::TAG_SCHEME;
		r = '0;
		if (req_len <= MAX_REQ)
			req_len++;
		tail_pair = {tail_pair[7:0], b};

		if (err_acc == NO_ERR && cur_phase != rufs_pkg::PH_STOP) begin
			if (b == rufs_pkg::CH_CR || b == rufs_pkg::CH_LF) begin
				// End of line: an open field at its limit wins over the emptiness checks.
				case (cur_phase)
					rufs_pkg::PH_SLASH1, rufs_pkg::PH_SLASH2: begin
						err_acc |= rufs_pkg::ERR_SCHEME;
						overfull = 1;
					end
					rufs_pkg::PH_DOMAIN: begin
						if (kept_len >= MAX_DOM) begin
							err_acc |= rufs_pkg::ERR_DOMAIN;
							overfull = 1;
						end else
							have_domain = kept_len > 0;
					end
					rufs_pkg::PH_PORT: begin
						if (kept_len >= MAX_PORT) begin
							err_acc |= rufs_pkg::ERR_PORT;
							overfull = 1;
						end
					end
					rufs_pkg::PH_PATH: begin
						if (kept_len >= MAX_PTH) begin
							err_acc |= rufs_pkg::ERR_PATH;
							overfull = 1;
						end
					end
					default: ;
				endcase
				if (!overfull) begin
					if (!have_scheme)
						err_acc |= rufs_pkg::ERR_SCHEME;
					if (!have_domain)
						err_acc |= rufs_pkg::ERR_DOMAIN;
				end
				cur_phase = rufs_pkg::PH_STOP;
			end else begin
				case (cur_phase)
					rufs_pkg::PH_SCHEME: begin
						if (kept_len >= MAX_SCH)
							err_acc |= rufs_pkg::ERR_SCHEME;
						else if (b == rufs_pkg::CH_COLON) begin
							have_scheme = kept_len > 0;
							kept_len = 0;
							cur_phase = rufs_pkg::PH_SLASH1;
						end else begin
							kept_len++;
							keep = 1;
							tag = rufs_pkg::TAG_SCHEME;
						end
					end
					rufs_pkg::PH_SLASH1, rufs_pkg::PH_SLASH2: begin
						if (b != rufs_pkg::CH_SLASH)
							err_acc |= rufs_pkg::ERR_SCHEME;
						else if (cur_phase == rufs_pkg::PH_SLASH1)
							cur_phase = rufs_pkg::PH_SLASH2;
						else
							cur_phase = rufs_pkg::PH_DOMAIN;
					end
					rufs_pkg::PH_DOMAIN: begin
						if (kept_len >= MAX_DOM)
							err_acc |= rufs_pkg::ERR_DOMAIN;
						else if (b == rufs_pkg::CH_COLON) begin
							have_domain = kept_len > 0;
							kept_len = 0;
							cur_phase = rufs_pkg::PH_PORT;
						end else if (b == rufs_pkg::CH_SLASH) begin
							// The opening slash is the first byte of the path.
							have_domain = kept_len > 0;
							kept_len = 1;
							cur_phase = rufs_pkg::PH_PATH;
							keep = 1;
							tag = rufs_pkg::TAG_PATH;
						end else begin
							kept_len++;
							keep = 1;
							tag = rufs_pkg::TAG_DOMAIN;
						end
					end
					rufs_pkg::PH_PORT: begin
						if (kept_len >= MAX_PORT)
							err_acc |= rufs_pkg::ERR_PORT;
						else if (b == rufs_pkg::CH_SLASH) begin
							kept_len = 1;
							cur_phase = rufs_pkg::PH_PATH;
							keep = 1;
							tag = rufs_pkg::TAG_PATH;
						end else begin
							kept_len++;
							keep = 1;
							tag = rufs_pkg::TAG_PORT;
						end
					end
					rufs_pkg::PH_PATH: begin
						if (kept_len >= MAX_PTH)
							err_acc |= rufs_pkg::ERR_PATH;
						else if (b == rufs_pkg::CH_QMARK) begin
							if (!have_domain)
								err_acc |= rufs_pkg::ERR_DOMAIN;
							cur_phase = rufs_pkg::PH_STOP;
						end else begin
							kept_len++;
							keep = 1;
							tag = rufs_pkg::TAG_PATH;
						end
					end
					default: ;
				endcase
			end
		end

		// The final byte yields only the status word.
		if (fin) begin
			r.st = 1'b1;
			r.flags = (tail_pair != rufs_pkg::TERM_CRLF || req_len > MAX_REQ) ?
				rufs_pkg::ERR_TERM : err_acc;
			clear_split_state();
			return 1;
		end
		if (keep) begin
			r.ch = b;
			r.tag = tag;
			return 1;
		end
		return 0;
	endfunction

	// Any byte except the characters that steer the parser, mostly letters.
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(9) < 7)
				c = 8'(8'h61 + $urandom_range(25));
			else
				c = 8'($urandom_range(255));
		end while (c == rufs_pkg::CH_COLON || c == rufs_pkg::CH_SLASH ||
			c == rufs_pkg::CH_QMARK || c == rufs_pkg::CH_CR || c == rufs_pkg::CH_LF);
		return c;
	endfunction

	// Field length: mostly short, sometimes empty, sometimes around the limit.
	function automatic int pick_len(input int typical, input int limit);
		int roll;
		roll = $urandom_range(19);
		if (roll < 2)
			return 0;
		if (roll < 5)
			return $urandom_range(limit + 1, limit - 2);
		return $urandom_range(typical, 1);
	endfunction

	// Well-formed request with random content, sometimes damaged afterwards.
	task automatic build_request();
		int n;
		line_buf.delete();
		n = pick_len(6, MAX_SCH);
		repeat (n) line_buf.push_back(plain_char());
		line_buf.push_back(rufs_pkg::CH_COLON);
		line_buf.push_back(rufs_pkg::CH_SLASH);
		line_buf.push_back(rufs_pkg::CH_SLASH);
		n = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
		repeat (n) line_buf.push_back(plain_char());
		if ($urandom_range(9) < 4) begin
			line_buf.push_back(rufs_pkg::CH_COLON);
			n = pick_len(4, MAX_PORT);
			repeat (n) line_buf.push_back(plain_char());
		end
		if ($urandom_range(9) < 7) begin
			line_buf.push_back(rufs_pkg::CH_SLASH);
			repeat ($urandom_range(10)) begin
				case ($urandom_range(9))
					0: line_buf.push_back(rufs_pkg::CH_COLON);
					1: line_buf.push_back(rufs_pkg::CH_SLASH);
					default: line_buf.push_back(plain_char());
				endcase
			end
		end
		if ($urandom_range(9) < 3) begin
			line_buf.push_back(rufs_pkg::CH_QMARK);
			repeat ($urandom_range(6)) line_buf.push_back(plain_char());
		end
		case ($urandom_range(19))
			0: ;
			1: line_buf.push_back(rufs_pkg::CH_LF);
			2: line_buf.push_back(rufs_pkg::CH_CR);
			3: begin
				line_buf.push_back(rufs_pkg::CH_LF);
				line_buf.push_back(rufs_pkg::CH_CR);
			end
			default: begin
				line_buf.push_back(rufs_pkg::CH_CR);
				line_buf.push_back(rufs_pkg::CH_LF);
			end
		endcase
		if ($urandom_range(4) == 0)
			line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
	endtask

	// Random bytes, sometimes closed by a proper line end.
	task automatic build_noise();
		line_buf.delete();
		repeat ($urandom_range(24, 1)) line_buf.push_back(8'($urandom_range(255)));
		if ($urandom_range(9) < 3) begin
			line_buf.push_back(rufs_pkg::CH_CR);
			line_buf.push_back(rufs_pkg::CH_LF);
		end
	endtask

	// Long requests that fill the domain or the path up to its limit.
	task automatic build_long(input int kind);
		line_buf.delete();
		line_buf.push_back("h");
		line_buf.push_back(rufs_pkg::CH_COLON);
		line_buf.push_back(rufs_pkg::CH_SLASH);
		line_buf.push_back(rufs_pkg::CH_SLASH);
		case (kind)
			LONG_DOMAIN: begin
				repeat (MAX_DOM) line_buf.push_back(plain_char());
			end
			default: begin
				line_buf.push_back("d");
				line_buf.push_back(rufs_pkg::CH_SLASH);
				repeat (MAX_PTH - 1) line_buf.push_back(plain_char());
			end
		endcase
		line_buf.push_back(rufs_pkg::CH_CR);
		line_buf.push_back(rufs_pkg::CH_LF);
	endtask

	// Offers one word, waits for it to be taken and records what it should yield.
	// Entered and left just after a falling edge.
	task automatic send_word(input logic [7:0] b, input logic fin, input logic pinned,
			input logic [4:0] pin_flags);
		result_t r;
		bit made;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		req_byte <= b;
		is_final <= fin;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		made = predict_split(b, fin, r);
		if (pinned) begin
			r = '0;
			r.st = 1'b1;
			r.flags = pin_flags;
			made = 1;
		end
		if (made)
			pending_results.push_back(r);
		@(negedge clk);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++)
			send_word(line_buf[i], i == line_buf.size() - 1, 1'b0, NO_ERR);
	endtask

	// Receiver side: stall at random.
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Compare each taken word with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0)
				log_mismatch($sformatf("unexpected word char=%02h tag=%0d st=%0b flags=%05b",
					field_char, field_tag, is_status, error_flags));
			else begin
				want = pending_results.pop_front();
				if (is_status !== want.st)
					log_mismatch($sformatf("is_status %0b, expected %0b", is_status, want.st));
				if (field_char !== want.ch)
					log_mismatch($sformatf("field_char %02h, expected %02h", field_char,
						want.ch));
				if (field_tag !== want.tag)
					log_mismatch($sformatf("field_tag %0d, expected %0d", field_tag, want.tag));
				if (error_flags !== want.flags)
					log_mismatch($sformatf("error_flags %05b, expected %05b", error_flags,
						want.flags));
			end
		end
	end

	initial begin
		int count;
		int drain;
		int ph;
		clear_split_state();

		// Directed words: final-only byte, a clean request, missing slashes, and
		// extreme bytes in the scheme, then every field up to a stop at the question mark.
		probes = '{
			'{"x", 1'b1, 1'b1, rufs_pkg::ERR_TERM},
			'{"a", 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_COLON, 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_SLASH, 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_SLASH, 1'b0, 1'b0, NO_ERR},
			'{"b", 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_CR, 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_LF, 1'b1, 1'b1, NO_ERR},
			'{rufs_pkg::CH_COLON, 1'b0, 1'b0, NO_ERR},
			'{"x", 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_CR, 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_LF, 1'b1, 1'b1, rufs_pkg::ERR_SCHEME},
			'{8'hFF, 1'b0, 1'b0, NO_ERR},
			'{8'h00, 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_COLON, 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_SLASH, 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_SLASH, 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_COLON, 1'b0, 1'b0, NO_ERR},
			'{"8", 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_SLASH, 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_QMARK, 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_CR, 1'b0, 1'b0, NO_ERR},
			'{rufs_pkg::CH_LF, 1'b1, 1'b1, rufs_pkg::ERR_DOMAIN}
		};

		// Reset is held, then released on a falling edge.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NPROBE; i++)
			send_word(probes[i].b, probes[i].fin, probes[i].pinned, probes[i].flags);

		// Random requests in three idling phases; the first two also carry one
		// long request that fills a field to its limit.
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 55;
				end
				1: begin
					send_idle_pct = 55;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (ph < 2) begin
				build_long(ph == 0 ? LONG_DOMAIN : LONG_PATH);
				send_line();
			end
			count = 0;
			while (count < SMALL_PER_PHASE) begin
				if ($urandom_range(4) == 0)
					build_noise();
				else
					build_request();
				count += line_buf.size();
				send_line();
			end
		end
		in_valid <= 1'b0;

		// Let the last words come out, then wait on for stray ones.
		drain = 0;
		while (pending_results.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			log_mismatch($sformatf("%0d expected words never arrived",
				pending_results.size()));

		if (mismatches == 0)
			$display("** request_uri_field_splitter_core: PASSED **");
		else
			$display("** request_uri_field_splitter_core: FAILED **");
		$finish;
	end
endmodule
